// ===== rtl/dofe_pkg.sv =====
// Package for the DHCP option field extractor.
// Holds parser phase codes, stop status codes, option tag codes and the
// result record type. It depends on nothing else.
`default_nettype none

package dofe_pkg;

  // Parser phase codes.
  localparam logic [1:0] PH_TAG  = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_VAL  = 2'd2;
  localparam logic [1:0] PH_HALT = 2'd3;

  // Stop status codes reported with each result.
  localparam logic [2:0] ST_EXHAUSTED = 3'd0;
  localparam logic [2:0] ST_END       = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_OVERLONG  = 3'd3;
  localparam logic [2:0] ST_ITER      = 3'd4;

  // Option tags that the parser acts on.
  localparam logic [7:0] OPT_PAD     = 8'd0;
  localparam logic [7:0] OPT_SUBNET  = 8'd1;
  localparam logic [7:0] OPT_ROUTER  = 8'd3;
  localparam logic [7:0] OPT_DNS     = 8'd6;
  localparam logic [7:0] OPT_LEASE   = 8'd51;
  localparam logic [7:0] OPT_MSGTYPE = 8'd53;
  localparam logic [7:0] OPT_SERVER  = 8'd54;
  localparam logic [7:0] OPT_END     = 8'd255;

  // Length of an address-sized option value in bytes.
  localparam logic [7:0] ADDR_LEN = 8'd4;

  // One result beat as produced by the parser.
  typedef struct packed {
    logic [7:0]  message_code;
    logic [31:0] server_id;
    logic [31:0] netmask;
    logic [31:0] router_addr;
    logic [31:0] dns_addr;
    logic [31:0] lease_seconds;
    logic [2:0]  stop_status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dofe_parse.sv =====
// Option record walker of the DHCP option field extractor.
// Holds the parse state and the captured fields, and forms the result
// for the final byte. Depends on dofe_pkg.
`default_nettype none

module dofe_parse #(
  parameter int MAX_ITERATIONS = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        opt_byte,
  input  logic              last,
  output dofe_pkg::result_t result
);
  import dofe_pkg::*;

  localparam int IterWidth = $clog2(MAX_ITERATIONS + 1);
  localparam logic [IterWidth-1:0] IterLimit = IterWidth'(MAX_ITERATIONS);

  logic [1:0]           phase, phase_next;
  logic [7:0]           cur_tag, cur_tag_next;
  logic [7:0]           cur_len, cur_len_next;
  logic [7:0]           value_index, value_index_next;
  logic [31:0]          pending_word, pending_word_next;
  logic [IterWidth-1:0] iter_count, iter_count_next;
  logic [2:0]           halt_code, halt_code_next;
  logic [7:0]           held_message_code, held_message_code_next;
  logic [31:0]          server_id, server_id_next;
  logic [31:0]          netmask, netmask_next;
  logic [31:0]          router_addr, router_addr_next;
  logic [31:0]          dns_addr, dns_addr_next;
  logic [31:0]          lease_seconds, lease_seconds_next;
  logic [7:0]           value_index_inc;
  logic                 commit;
  logic [7:0]           msg_byte;

  always_comb begin
    phase_next         = phase;
    cur_tag_next       = cur_tag;
    cur_len_next       = cur_len;
    value_index_next   = value_index;
    pending_word_next  = pending_word;
    iter_count_next    = iter_count;
    halt_code_next     = halt_code;
    commit             = 1'b0;
    value_index_inc    = value_index + 8'd1;

    unique case (phase)
      PH_TAG: begin
        if (iter_count >= IterLimit) begin
          phase_next     = PH_HALT;
          halt_code_next = ST_ITER;
        end else begin
          iter_count_next = iter_count + 1'b1;
          if (opt_byte == OPT_END) begin
            phase_next     = PH_HALT;
            halt_code_next = ST_END;
          end else if (opt_byte != OPT_PAD) begin
            cur_tag_next = opt_byte;
            if (last) begin
              phase_next     = PH_HALT;
              halt_code_next = ST_TRUNC;
            end else begin
              phase_next = PH_LEN;
            end
          end
        end
      end
      PH_LEN: begin
        cur_len_next      = opt_byte;
        value_index_next  = 8'd0;
        pending_word_next = 32'd0;
        if (opt_byte == 8'd0) begin
          phase_next = PH_TAG;
        end else if (last) begin
          phase_next     = PH_HALT;
          halt_code_next = ST_OVERLONG;
        end else begin
          phase_next = PH_VAL;
        end
      end
      PH_VAL: begin
        // Only the first four value bytes are kept.
        if (value_index < ADDR_LEN) begin
          pending_word_next = {pending_word[23:0], opt_byte};
        end
        value_index_next = value_index_inc;
        if (value_index_inc == cur_len) begin
          commit     = 1'b1;
          phase_next = PH_TAG;
        end else if (last) begin
          phase_next     = PH_HALT;
          halt_code_next = ST_OVERLONG;
        end
      end
      default: begin
        // Halted: bytes are ignored until the final one.
      end
    endcase
  end

  // The message type is the first value byte, which sits at the top of
  // however many bytes were gathered.
  always_comb begin
    case (cur_len)
      8'd1:    msg_byte = pending_word_next[7:0];
      8'd2:    msg_byte = pending_word_next[15:8];
      8'd3:    msg_byte = pending_word_next[23:16];
      default: msg_byte = pending_word_next[31:24];
    endcase
  end

  always_comb begin
    held_message_code_next = held_message_code;
    server_id_next         = server_id;
    netmask_next           = netmask;
    router_addr_next       = router_addr;
    dns_addr_next          = dns_addr;
    lease_seconds_next     = lease_seconds;
    if (commit) begin
      case (cur_tag)
        OPT_MSGTYPE: held_message_code_next = msg_byte;
        OPT_SERVER: begin
          if (cur_len == ADDR_LEN) server_id_next = pending_word_next;
        end
        OPT_SUBNET: begin
          if (cur_len == ADDR_LEN) netmask_next = pending_word_next;
        end
        OPT_ROUTER: begin
          if (cur_len >= ADDR_LEN) router_addr_next = pending_word_next;
        end
        OPT_DNS: begin
          if (cur_len >= ADDR_LEN) dns_addr_next = pending_word_next;
        end
        OPT_LEASE: begin
          if (cur_len == ADDR_LEN) lease_seconds_next = pending_word_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.message_code  = held_message_code_next;
    result.server_id     = server_id_next;
    result.netmask       = netmask_next;
    result.router_addr   = router_addr_next;
    result.dns_addr      = dns_addr_next;
    result.lease_seconds = lease_seconds_next;
    result.stop_status   = (phase_next == PH_HALT) ? halt_code_next : ST_EXHAUSTED;
  end

  // The final byte of an area returns everything to the reset state.
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase             <= PH_TAG;
      cur_tag           <= 8'd0;
      cur_len           <= 8'd0;
      value_index       <= 8'd0;
      pending_word      <= 32'd0;
      iter_count        <= '0;
      halt_code         <= ST_EXHAUSTED;
      held_message_code <= 8'd0;
      server_id         <= 32'd0;
      netmask           <= 32'd0;
      router_addr       <= 32'd0;
      dns_addr          <= 32'd0;
      lease_seconds     <= 32'd0;
    end else if (step) begin
      phase             <= phase_next;
      cur_tag           <= cur_tag_next;
      cur_len           <= cur_len_next;
      value_index       <= value_index_next;
      pending_word      <= pending_word_next;
      iter_count        <= iter_count_next;
      halt_code         <= halt_code_next;
      held_message_code <= held_message_code_next;
      server_id         <= server_id_next;
      netmask           <= netmask_next;
      router_addr       <= router_addr_next;
      dns_addr          <= dns_addr_next;
      lease_seconds     <= lease_seconds_next;
    end
  end

  a_iter_bounded: assert property (@(posedge clk) disable iff (rst)
    iter_count <= IterLimit)
    else $error("iteration count ran past its limit");

  a_halt_code_set: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HALT) == (halt_code != ST_EXHAUSTED))
    else $error("halt code does not agree with the halted phase");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (step && last) |=> (phase == PH_TAG && iter_count == '0))
    else $error("parser not cleared after the final byte");

endmodule

`default_nettype wire

// ===== rtl/dofe_out.sv =====
// Result register of the DHCP option field extractor.
// Holds one finished result until the consumer takes it. Depends on dofe_pkg.
`default_nettype none

module dofe_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dofe_pkg::result_t result,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [7:0]        message_code,
  output logic [31:0]       server_id,
  output logic [31:0]       netmask,
  output logic [31:0]       router_addr,
  output logic [31:0]       dns_addr,
  output logic [31:0]       lease_seconds,
  output logic [2:0]        stop_status
);
  import dofe_pkg::*;

  result_t held;
  logic    res_valid_next;

  assign res_valid_next = load || (res_valid && res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign message_code  = held.message_code;
  assign server_id     = held.server_id;
  assign netmask       = held.netmask;
  assign router_addr   = held.router_addr;
  assign dns_addr      = held.dns_addr;
  assign lease_seconds = held.lease_seconds;
  assign stop_status   = held.stop_status;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!res_valid || !res_stall))
    else $error("result register loaded while a result is still held");

endmodule

`default_nettype wire

// ===== rtl/dhcp_option_field_extractor.sv =====
// DHCP option field extractor, top level: input register, parser and result register.
// Path: a final beat goes through the input register and the parser into the result register.
// Throughput: one beat per cycle, held back only while a stalled result still
//   occupies the result register and the next final beat is waiting.
// Reset (rst, synchronous) empties both registers and clears the parser.
`default_nettype none

module dhcp_option_field_extractor #(
  parameter int MAX_ITERATIONS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        opt_valid,
  output logic        opt_stall,
  input  logic [7:0]  opt_byte,
  input  logic        last,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  message_code,
  output logic [31:0] server_id,
  output logic [31:0] netmask,
  output logic [31:0] router_addr,
  output logic [31:0] dns_addr,
  output logic [31:0] lease_seconds,
  output logic [2:0]  stop_status
);
  import dofe_pkg::*;

  // Input register. Each accepted beat lands here and waits until it is
  // handed to the parser.
  logic       ib_valid;
  logic [7:0] ib_byte;
  logic       ib_last;

  // The beat in the input register moves on whenever it is not a final
  // beat that would overwrite a result still waiting downstream. Ordinary
  // bytes never wait, since they only update the parser state.
  logic    step;
  logic    take;
  result_t result;

  assign step      = ib_valid && !(ib_last && res_valid && res_stall);
  assign opt_stall = ib_valid && !step;
  assign take      = opt_valid && !opt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (take) begin
      ib_valid <= 1'b1;
    end else if (step) begin
      ib_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ib_byte <= opt_byte;
      ib_last <= last;
    end
  end

  // The parser walks tag, length and value records; on a final beat it
  // also presents the finished result and clears itself.
  dofe_parse #(
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .opt_byte (ib_byte),
    .last     (ib_last),
    .result   (result)
  );

  // The result register frees the parser to start on the next area while
  // the previous result waits to be taken.
  dofe_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step && ib_last),
    .result        (result),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .message_code  (message_code),
    .server_id     (server_id),
    .netmask       (netmask),
    .router_addr   (router_addr),
    .dns_addr      (dns_addr),
    .lease_seconds (lease_seconds),
    .stop_status   (stop_status)
  );

  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    (step && ib_last) |=> res_valid)
    else $error("final beat did not produce a result");

  a_plain_byte_flows: assert property (@(posedge clk) disable iff (rst)
    (ib_valid && !ib_last) |-> step)
    else $error("a non-final beat was held in the input register");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the DHCP option field extractor: random and directed option areas,
// an in-bench parser that predicts each result beat, and a scoreboard that checks them.
// Depends on rtl/dofe_pkg.sv and rtl/dhcp_option_field_extractor.sv.
`timescale 1ns / 100ps

module tb_top;
  import dofe_pkg::*;

  // The iteration limit of the parser. The instance gets the same value.
  localparam int MAX_TAGS = 512;
  // Random stimulus stops once this many bytes have gone in, counting every
  // kind of area; with the directed areas this makes about a thousand beats.
  localparam int RANDOM_BYTES = 975;
  // The receiver holds off this long once, so that the block backs up.
  localparam int HOLD_CYCLES = 300;
  // A run ends in failure after this many cycles in which no beat moves on
  // either side. The hold-off above is the longest legal quiet spell.
  localparam int WATCHDOG_LIMIT = 3000;
  // A result shows after its final beat passes both registers; allow some margin.
  localparam int DRAIN_CYCLES = 8;

  // One options area. The final byte carries the last flag.
  typedef logic [7:0] area_t[$];

  // Scoreboard with its own parser. Every accepted byte goes through the parser,
  // and every final byte leaves one expected result in a queue. Result beats
  // from the block are compared against the oldest entry.
  class dhcp_field_scoreboard;
    logic [1:0]  phase;
    logic [7:0]  cur_tag;
    logic [7:0]  cur_len;
    logic [7:0]  value_index;
    logic [31:0] pending_word;
    logic [9:0]  tag_count;
    logic [9:0]  max_tags;
    logic [2:0]  halt_code;
    result_t     held;
    result_t     pending_results[$];
    int          errors;

    function new(int limit);
      max_tags = 10'(limit);
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_TAG;
      cur_tag = '0;
      cur_len = '0;
      value_index = '0;
      pending_word = '0;
      tag_count = '0;
      halt_code = ST_EXHAUSTED;
      held = '0;
    endfunction

    function void halt(logic [2:0] code);
      phase = PH_HALT;
      halt_code = code;
    endfunction

    // An option takes effect only once its whole value has been seen.
    function void commit();
      logic [7:0] n;
      n = (cur_len < ADDR_LEN) ? cur_len : ADDR_LEN;
      case (cur_tag)
        OPT_MSGTYPE: begin
          // The message type is the first value byte, whatever the length.
          held.message_code = 8'(pending_word >> {n - 8'd1, 3'b000});
        end
        OPT_SERVER: if (cur_len == ADDR_LEN) held.server_id = pending_word;
        OPT_SUBNET: if (cur_len == ADDR_LEN) held.netmask = pending_word;
        OPT_ROUTER: if (cur_len >= ADDR_LEN) held.router_addr = pending_word;
        OPT_DNS:    if (cur_len >= ADDR_LEN) held.dns_addr = pending_word;
        OPT_LEASE:  if (cur_len == ADDR_LEN) held.lease_seconds = pending_word;
        default: ;
      endcase
    endfunction

    function void note_beat(logic [7:0] b, logic is_last);
      result_t done;
      case (phase)
        PH_TAG: begin
          if (tag_count >= max_tags) begin
            halt(ST_ITER);
          end else begin
            tag_count++;
            if (b == OPT_END) begin
              halt(ST_END);
            end else if (b != OPT_PAD) begin
              cur_tag = b;
              phase = PH_LEN;
              if (is_last) halt(ST_TRUNC);
            end
          end
        end
        PH_LEN: begin
          cur_len = b;
          value_index = '0;
          pending_word = '0;
          if (b == 8'd0) begin
            phase = PH_TAG;
          end else begin
            phase = PH_VAL;
            if (is_last) halt(ST_OVERLONG);
          end
        end
        PH_VAL: begin
          // Only the first four value bytes are kept.
          if (value_index < ADDR_LEN) pending_word = {pending_word[23:0], b};
          value_index++;
          if (value_index == cur_len) begin
            commit();
            phase = PH_TAG;
          end else if (is_last) begin
            halt(ST_OVERLONG);
          end
        end
        default: ;
      endcase
      if (is_last) begin
        done = held;
        done.stop_status = (phase == PH_HALT) ? halt_code : ST_EXHAUSTED;
        pending_results.push_back(done);
        clear();
      end
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("result beat with none expected, stop status %0d", got.stop_status);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.message_code !== want.message_code)
        report("message_code", 32'(want.message_code), 32'(got.message_code));
      if (got.server_id !== want.server_id)
        report("server_id", want.server_id, got.server_id);
      if (got.netmask !== want.netmask)
        report("netmask", want.netmask, got.netmask);
      if (got.router_addr !== want.router_addr)
        report("router_addr", want.router_addr, got.router_addr);
      if (got.dns_addr !== want.dns_addr)
        report("dns_addr", want.dns_addr, got.dns_addr);
      if (got.lease_seconds !== want.lease_seconds)
        report("lease_seconds", want.lease_seconds, got.lease_seconds);
      if (got.stop_status !== want.stop_status)
        report("stop_status", 32'(want.stop_status), 32'(got.stop_status));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        opt_valid;
  logic        opt_stall;
  logic [7:0]  opt_byte;
  logic        last;
  logic        res_valid;
  logic        res_stall;
  logic [7:0]  message_code;
  logic [31:0] server_id;
  logic [31:0] netmask;
  logic [31:0] router_addr;
  logic [31:0] dns_addr;
  logic [31:0] lease_seconds;
  logic [2:0]  stop_status;

  // Idle switches for the two sides, and the one-shot request for the long
  // receiver hold-off. The stimulus process sets them; the drivers read them.
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_off_req = 1'b0;

  int quiet_cycles = 0;
  dhcp_field_scoreboard sb;

  dhcp_option_field_extractor #(
    .MAX_ITERATIONS(MAX_TAGS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .opt_valid(opt_valid),
    .opt_stall(opt_stall),
    .opt_byte(opt_byte),
    .last(last),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .message_code(message_code),
    .server_id(server_id),
    .netmask(netmask),
    .router_addr(router_addr),
    .dns_addr(dns_addr),
    .lease_seconds(lease_seconds),
    .stop_status(stop_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offers the bytes of one area in order. Before each byte the sender may
  // idle for a few cycles. Once a byte is up, it stays put until the block
  // takes it. Valid is only lowered in an idle cycle, so a byte that follows
  // an accepted one is never lowered and raised in the same step.
  task automatic send_area(input area_t q);
    foreach (q[k]) begin
      while (tx_idle_on && $urandom_range(99) < 23) begin
        opt_valid <= 1'b0;
        @(posedge clk);
      end
      opt_valid <= 1'b1;
      opt_byte <= q[k];
      last <= (k == q.size() - 1);
      @(posedge clk);
      while (opt_stall) @(posedge clk);
    end
  endtask

  // Builds an options area. Most are well formed: a few records, a mix of
  // the captured options at their natural lengths and of other tags, odd
  // lengths now and then, and often an END with some trailing bytes that the
  // block should ignore. The rest are cut off at a random byte, which lands
  // on tags, length bytes and values alike, or are plain noise.
  function automatic area_t make_area();
    area_t q;
    int recs;
    int len;
    int cut;
    logic [7:0] tag;
    recs = $urandom_range(5);
    for (int r = 0; r < recs; r++) begin
      if ($urandom_range(9) == 0) begin
        q.push_back(OPT_PAD);
        continue;
      end
      case ($urandom_range(7))
        0: tag = OPT_SUBNET;
        1: tag = OPT_ROUTER;
        2: tag = OPT_DNS;
        3: tag = OPT_LEASE;
        4: tag = OPT_MSGTYPE;
        5: tag = OPT_SERVER;
        default: tag = 8'($urandom_range(1, 254));
      endcase
      // A long value is rare, since every value byte has to be sent.
      if ($urandom_range(39) == 0) len = $urandom_range(255);
      else if ($urandom_range(3) == 0) len = $urandom_range(8);
      else len = (tag == OPT_MSGTYPE) ? 1 : int'(ADDR_LEN);
      q.push_back(tag);
      q.push_back(8'(len));
      repeat (len) q.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(3) != 0) begin
      q.push_back(OPT_END);
      repeat ($urandom_range(3)) q.push_back(8'($urandom_range(255)));
    end
    if (q.size() == 0) q.push_back(OPT_PAD);
    case ($urandom_range(9))
      0, 1: begin
        cut = $urandom_range(1, q.size());
        while (q.size() > cut) void'(q.pop_back());
      end
      2: begin
        q.delete();
        repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(255)));
      end
      default: ;
    endcase
    return q;
  endfunction

  // A run of pads around the iteration limit, so that the limit is crossed
  // on some runs and only just reached on others.
  function automatic area_t make_pad_run();
    area_t q;
    repeat ($urandom_range(MAX_TAGS - 6, MAX_TAGS + 4)) q.push_back(OPT_PAD);
    case ($urandom_range(2))
      0: q.push_back(OPT_END);
      1: begin
        q.push_back(OPT_MSGTYPE);
        q.push_back(8'd1);
        q.push_back(8'($urandom_range(255)));
        q.push_back(OPT_END);
      end
      default: ;
    endcase
    return q;
  endfunction

  // Receiver: stalls in about a quarter of the cycles while idling is on.
  // On request it holds off for a long stretch, counted here, while the
  // sender keeps offering short areas until the block stops taking bytes.
  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_stall <= rx_idle_on && ($urandom_range(99) < 23);
    end
  end

  // Both handshakes are sampled at the rising edge, before any of this
  // step's updates land, so the values seen are the ones the block saw.
  // The watchdog counts cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (opt_valid && !opt_stall) sb.note_beat(opt_byte, last);
      if (res_valid && !res_stall) begin
        sb.check_result({message_code, server_id, netmask, router_addr, dns_addr,
                         lease_seconds, stop_status});
      end
      if ((opt_valid && !opt_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    area_t area;
    int sent_bytes;
    sb = new(MAX_TAGS);
    rst <= 1'b1;
    opt_valid <= 1'b0;
    opt_byte <= '0;
    last <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed areas. A message type followed by END, after which the
    // remaining bytes must be ignored.
    area = '{OPT_MSGTYPE, 8'd1, 8'd5, OPT_END, 8'hAA, 8'h13};
    send_area(area);
    // An all-ones server identifier, then a tag on the final byte.
    area = '{OPT_SERVER, ADDR_LEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, OPT_SUBNET};
    send_area(area);
    // A skipped zero-length option, then a nonzero length on the final byte.
    area = '{8'd200, 8'd0, OPT_ROUTER, ADDR_LEN};
    send_area(area);
    // A lease time whose value is cut short: nothing may be committed.
    area = '{OPT_LEASE, ADDR_LEN, 8'h00, 8'h01, 8'h02};
    send_area(area);
    // A zero length on the final byte closes the record cleanly.
    area = '{OPT_DNS, 8'd0};
    send_area(area);
    // A lone pad.
    area = '{OPT_PAD};
    send_area(area);

    // Random areas. First the receiver holds off while single-byte areas
    // pile up behind the stalled result. Then one pad run tests the
    // iteration limit, and later comes a stretch with no idling on either
    // side.
    sent_bytes = 0;
    for (int a = 0; sent_bytes < RANDOM_BYTES; a++) begin
      tx_idle_on = !(a >= 18 && a < 30);
      rx_idle_on = !(a >= 18 && a < 30);
      if (a == 0) hold_off_req = 1'b1;
      if (a < 15) begin
        area = '{8'($urandom_range(255))};
      end else if (a == 15) begin
        area = make_pad_run();
      end else begin
        area = make_area();
      end
      sent_bytes += area.size();
      send_area(area);
    end
    opt_valid <= 1'b0;

    // Wait for every expected result, then a few more cycles to catch any
    // stray result beat.
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
